FILE: rtl/lrt_pkg.sv
// shared types and constants for the lru room memory table
// no dependencies; imported by every module of the block
package lrt_pkg;

	localparam int ENTRIES     = 8;
	localparam int SLOT_W      = $clog2(ENTRIES);
	localparam int OUT_SLOT_W  = 3;
	localparam int TAG_W       = 8;
	localparam int AGE_W       = 16;
	localparam int MASK_W      = 32;
	localparam int BIT_W       = $clog2(MASK_W);
	localparam int IDX_W       = 8;
	localparam int MARK_BIT    = 7;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		MODE_CLEAR = 2'd0,
		MODE_ENTER = 2'd1,
		MODE_MARK  = 2'd2,
		MODE_QUERY = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t              mode;
		logic [TAG_W-1:0]   area;
		logic [TAG_W-1:0]   room;
		logic               mark_en;
		logic [BIT_W-1:0]   bit_sel;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic {
		BK_EXEC = 1'b0,
		BK_AGE  = 1'b1
	} back_state_t;

endpackage

FILE: rtl/lrt_front.sv
// front end: takes input beats and classifies them into commands
// depends on lrt_pkg; feeds lrt_queue
module lrt_front import lrt_pkg::*; (
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         mode,
	input  logic [TAG_W-1:0]   area_id,
	input  logic [TAG_W-1:0]   room_id,
	input  logic [IDX_W-1:0]   enemy_index,
	input  q_stat_t            q_stat,
	output logic               push,
	output cmd_t               cmd
);

	assign in_stall = q_stat.full;
	assign push     = in_valid && !q_stat.full;

	always_comb begin
		cmd.mode    = mode_t'(mode);
		cmd.area    = area_id;
		cmd.room    = room_id;
		// mark only acts with the gate bit set; other index bits above the select are dropped
		cmd.mark_en = enemy_index[MARK_BIT];
		cmd.bit_sel = enemy_index[BIT_W-1:0];
	end

endmodule

FILE: rtl/lrt_queue.sv
// short command queue between front and back end
// depends on lrt_pkg
module lrt_queue import lrt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  cmd_t    push_cmd,
	input  logic    pop,
	output cmd_t    head_cmd,
	output q_stat_t q_stat
);

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;

	assign q_stat.full  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign head_cmd     = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: rtl/lrt_back.sv
// back end: holds the table, runs commands and drives the result register
// depends on lrt_pkg; reads commands from lrt_queue
module lrt_back import lrt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  head_cmd,
	input  q_stat_t               q_stat,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  respawn_allowed,
	output logic [OUT_SLOT_W-1:0] current_slot,
	output logic                  room_hit
);

	logic [TAG_W-1:0]  area_q [ENTRIES];
	logic [TAG_W-1:0]  room_q [ENTRIES];
	logic [AGE_W-1:0]  age_q  [ENTRIES];
	logic [MASK_W-1:0] mask_q [ENTRIES];
	logic [SLOT_W-1:0] cur_q;

	back_state_t state_q, state_d;

	logic [SLOT_W-1:0] sel_s1;
	logic              hit_s1;
	logic [TAG_W-1:0]  area_s1;
	logic [TAG_W-1:0]  room_s1;

	logic              out_valid_q;
	logic              out_respawn_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic              out_hit_q;

	logic              out_ok;
	logic              exec_go;
	logic              age_go;
	logic              enter_go;
	logic              hit_c;
	logic [SLOT_W-1:0] hit_idx_c;
	logic [SLOT_W-1:0] old_idx_c;
	logic [AGE_W-1:0]  pivot_c;

	assign out_ok = !out_valid_q || !out_stall;

	// tag lookup, lowest matching entry wins
	always_comb begin
		hit_c     = 1'b0;
		hit_idx_c = '0;
		for (int i = ENTRIES-1; i >= 0; i--) begin
			if (area_q[i] == head_cmd.area && room_q[i] == head_cmd.room) begin
				hit_c     = 1'b1;
				hit_idx_c = SLOT_W'(i);
			end
		end
	end

	// oldest entry, first one wins a tie
	always_comb begin
		logic [AGE_W-1:0] best_age;
		best_age  = age_q[0];
		old_idx_c = '0;
		for (int i = 1; i < ENTRIES; i++) begin
			if (age_q[i] > best_age) begin
				best_age  = age_q[i];
				old_idx_c = SLOT_W'(i);
			end
		end
	end

	// a replaced entry ages as if it held all ones
	assign pivot_c = hit_s1 ? age_q[sel_s1] : '1;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_EXEC: begin
				if (enter_go) begin
					state_d = BK_AGE;
				end
			end
			BK_AGE: begin
				if (out_ok) begin
					state_d = BK_EXEC;
				end
			end
			default: state_d = BK_EXEC;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		exec_go  = 1'b0;
		enter_go = 1'b0;
		age_go   = 1'b0;
		unique case (state_q)
			BK_EXEC: begin
				pop      = !q_stat.empty && out_ok;
				enter_go = pop && (head_cmd.mode == MODE_ENTER);
				exec_go  = pop && (head_cmd.mode != MODE_ENTER);
			end
			BK_AGE: begin
				age_go = out_ok;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_EXEC;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (enter_go) begin
			sel_s1  <= hit_c ? hit_idx_c : old_idx_c;
			hit_s1  <= hit_c;
			area_s1 <= head_cmd.area;
			room_s1 <= head_cmd.room;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				area_q[i] <= '1;
				room_q[i] <= '1;
				age_q[i]  <= '1;
				mask_q[i] <= '1;
			end
			cur_q <= '0;
		end else if (exec_go) begin
			unique case (head_cmd.mode)
				MODE_CLEAR: begin
					for (int i = 0; i < ENTRIES; i++) begin
						area_q[i] <= '1;
						room_q[i] <= '1;
						age_q[i]  <= '1;
						mask_q[i] <= '1;
					end
					cur_q <= '0;
				end
				MODE_MARK: begin
					if (head_cmd.mark_en) begin
						mask_q[cur_q][head_cmd.bit_sel] <= 1'b1;
					end
				end
				default: ;
			endcase
		end else if (age_go) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (SLOT_W'(i) == sel_s1) begin
					age_q[i] <= '0;
				end else if (age_q[i] < pivot_c) begin
					age_q[i] <= age_q[i] + 1'b1;
				end
			end
			if (!hit_s1) begin
				area_q[sel_s1] <= area_s1;
				room_q[sel_s1] <= room_s1;
				mask_q[sel_s1] <= '0;
			end
			cur_q <= sel_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_go || age_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go) begin
			out_respawn_q <= (head_cmd.mode == MODE_QUERY) && !mask_q[cur_q][head_cmd.bit_sel];
			out_slot_q    <= (head_cmd.mode == MODE_CLEAR) ? '0 : cur_q;
			out_hit_q     <= 1'b0;
		end else if (age_go) begin
			out_respawn_q <= 1'b0;
			out_slot_q    <= sel_s1;
			out_hit_q     <= hit_s1;
		end
	end

	assign out_valid       = out_valid_q;
	assign respawn_allowed = out_respawn_q;
	assign current_slot    = OUT_SLOT_W'(out_slot_q);
	assign room_hit        = out_hit_q;

endmodule

FILE: rtl/lru_room_memory_table_unit.sv
// top level of the lru room memory table: front end, command queue, back end
// depends on lrt_pkg, lrt_front, lrt_queue, lrt_back
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  input   | in_valid / in_stall  | mode, area_id, room_id, enemy_index
//  output  | out_valid / out_stall| respawn_allowed, current_slot, room_hit
//
// clear, mark and query are done in state BK_EXEC alone; enter passes through BK_EXEC for
// the tag match and oldest-age search and then BK_AGE for the aging update.
// a two-beat command queue lets the input side keep taking beats while a
// result waits in the output register.
// reset sets every tag, age and mask to all ones and points at slot 0; no
// clearing pass, the table is usable the cycle after reset.
module lru_room_memory_table_unit import lrt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            mode,
	input  logic [TAG_W-1:0]      area_id,
	input  logic [TAG_W-1:0]      room_id,
	input  logic [IDX_W-1:0]      enemy_index,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  respawn_allowed,
	output logic [OUT_SLOT_W-1:0] current_slot,
	output logic                  room_hit
);

	q_stat_t q_stat;
	cmd_t    push_cmd;
	cmd_t    head_cmd;
	logic    push;
	logic    pop;

	lrt_front u_front (
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.area_id     (area_id),
		.room_id     (room_id),
		.enemy_index (enemy_index),
		.q_stat      (q_stat),
		.push        (push),
		.cmd         (push_cmd)
	);

	lrt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.q_stat   (q_stat)
	);

	lrt_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head_cmd        (head_cmd),
		.q_stat          (q_stat),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.respawn_allowed (respawn_allowed),
		.current_slot    (current_slot),
		.room_hit        (room_hit)
	);

endmodule

FILE: rtl/lrt_checker.sv
// port-level checks for lru_room_memory_table_unit, attached by bind
// depends on lrt_pkg
module lrt_checker import lrt_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic [1:0]            mode,
	input logic [TAG_W-1:0]      area_id,
	input logic [TAG_W-1:0]      room_id,
	input logic [IDX_W-1:0]      enemy_index,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic                  respawn_allowed,
	input logic [OUT_SLOT_W-1:0] current_slot,
	input logic                  room_hit
);

	// a stalled input beat holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(mode) && $stable(area_id)
			&& $stable(room_id) && $stable(enemy_index))
		else $error("input beat changed while stalled");

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(respawn_allowed)
			&& $stable(current_slot) && $stable(room_hit))
		else $error("result beat changed while stalled");

	// query and enter results are exclusive
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(respawn_allowed && room_hit))
		else $error("respawn_allowed and room_hit both set");

	// with the output side quiet throughout the antecedent the queue must have drained
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid ##1 !out_valid ##1 !out_valid |-> !in_stall)
		else $error("input stalled while back end idle");

	// the slot reported never leaves the table
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(current_slot) <= 32'(ENTRIES-1)))
		else $error("current_slot out of range");

endmodule

bind lru_room_memory_table_unit lrt_checker u_lrt_checker (.*);

FILE: bench/lrt_room_table_checker.sv
// checker for the lru room memory table: watches both channels, predicts every result
// from its own copy of the table and compares it field by field
// depends on lrt_pkg
module lrt_room_table_checker import lrt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [1:0]            mode,
	input  logic [TAG_W-1:0]      area_id,
	input  logic [TAG_W-1:0]      room_id,
	input  logic [IDX_W-1:0]      enemy_index,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic                  respawn_allowed,
	input  logic [OUT_SLOT_W-1:0] current_slot,
	input  logic                  room_hit,
	output int                    mismatches,
	output int                    outstanding
);

	typedef struct packed {
		logic                  respawn;
		logic [OUT_SLOT_W-1:0] slot;
		logic                  hit;
	} room_result_t;

	logic [TAG_W-1:0]  area_tag [ENTRIES];
	logic [TAG_W-1:0]  room_tag [ENTRIES];
	logic [AGE_W-1:0]  age      [ENTRIES];
	logic [MASK_W-1:0] defeated [ENTRIES];
	int unsigned       cur;
	room_result_t      expected_rooms [$];

	task automatic wipe_table();
		for (int i = 0; i < ENTRIES; i++) begin
			area_tag[i] = '1;
			room_tag[i] = '1;
			age[i]      = '1;
			defeated[i] = '1;
		end
		cur = 0;
	endtask

	task automatic predict_room_step(input mode_t op, input logic [TAG_W-1:0] area,
			input logic [TAG_W-1:0] room, input logic [IDX_W-1:0] idx,
			output room_result_t res);
		int               sel;
		logic [AGE_W-1:0] pivot;
		logic [BIT_W-1:0] bsel;
		sel  = -1;
		bsel = idx[BIT_W-1:0];
		res  = '0;
		case (op)
		MODE_CLEAR: begin
			wipe_table();
		end
		MODE_ENTER: begin
			// lowest matching index wins when tags repeat
			for (int i = 0; i < ENTRIES; i++)
				if (sel < 0 && area_tag[i] == area && room_tag[i] == room)
					sel = i;
			res.hit = (sel >= 0);
			if (sel < 0) begin
				// miss: evict the oldest, first one on a tie
				sel = 0;
				for (int i = 1; i < ENTRIES; i++)
					if (age[i] > age[sel])
						sel = i;
				area_tag[sel] = area;
				room_tag[sel] = room;
				age[sel]      = '1;
				defeated[sel] = '0;
			end
			pivot = age[sel];
			for (int i = 0; i < ENTRIES; i++)
				if (age[i] < pivot)
					age[i] = age[i] + 1'b1;
			age[sel] = '0;
			cur      = sel;
		end
		MODE_MARK: begin
			if (idx[MARK_BIT])
				defeated[cur][bsel] = 1'b1;
		end
		default: begin
			res.respawn = ~defeated[cur][bsel];
		end
		endcase
		res.slot = cur[OUT_SLOT_W-1:0];
	endtask

	always @(posedge clk or negedge arst_n) begin
		room_result_t want;
		room_result_t got;
		if (!arst_n) begin
			wipe_table();
			expected_rooms.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			// retire the result beat first so a fresh prediction never hides an extra beat
			if (out_valid && !out_stall) begin
				got = '{respawn: respawn_allowed, slot: current_slot, hit: room_hit};
				if (expected_rooms.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat: respawn %0b slot %0d hit %0b",
							got.respawn, got.slot, got.hit);
				end else begin
					want = expected_rooms.pop_front();
					if (got.respawn !== want.respawn || got.slot !== want.slot ||
							got.hit !== want.hit) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result beat differs: respawn %0b/%0b slot %0d/%0d hit %0b/%0b",
								want.respawn, got.respawn, want.slot, got.slot,
								want.hit, got.hit);
					end
				end
			end
			if (in_valid && !in_stall) begin
				predict_room_step(mode_t'(mode), area_id, room_id, enemy_index, want);
				expected_rooms.push_back(want);
			end
			outstanding = expected_rooms.size();
		end
	end

endmodule

FILE: bench/tb_lru_room_memory_table_unit.sv
// testbench top for the lru room memory table: clock, reset, command beats and result
// back-pressure; verdict comes from lrt_room_table_checker
// depends on lrt_pkg, lru_room_memory_table_unit, lrt_room_table_checker
module tb_lru_room_memory_table_unit;
	import lrt_pkg::*;

	localparam int RANDOM_BEATS = 1625;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 16;
	localparam int HOLD_CYCLES  = 200;
	localparam int HOLD_AT      = 400;
	localparam int QUIET_FROM   = 900;
	localparam int QUIET_TO     = 1200;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [1:0]            mode;
	logic [TAG_W-1:0]      area_id;
	logic [TAG_W-1:0]      room_id;
	logic [IDX_W-1:0]      enemy_index;
	logic                  out_valid;
	logic                  out_stall;
	logic                  respawn_allowed;
	logic [OUT_SLOT_W-1:0] current_slot;
	logic                  room_hit;
	int                    mismatches;
	int                    outstanding;
	int                    beats_sent = 0;
	int                    cycles = 0;

	lru_room_memory_table_unit i_dut (.*);

	lrt_room_table_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("lru_room_memory_table_unit: mismatch");
			$finish;
		end
	end

	// random gaps everywhere except one quiet stretch of the run
	function automatic logic idle_now();
		if (beats_sent >= QUIET_FROM && beats_sent < QUIET_TO)
			return 1'b0;
		return $urandom_range(99) < 26;
	endfunction

	task automatic send_beat(input mode_t op, input logic [TAG_W-1:0] area,
			input logic [TAG_W-1:0] room, input logic [IDX_W-1:0] idx);
		while (idle_now()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		mode        <= op;
		area_id     <= area;
		room_id     <= room;
		enemy_index <= idx;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		beats_sent++;
	endtask

	initial begin
		int          hold_count;
		logic        hold_done;
		hold_done = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (!hold_done && beats_sent >= HOLD_AT) begin
				// long hold-off so the queue fills and the input stalls
				hold_done = 1'b1;
				out_stall <= 1'b1;
				for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++)
					@(posedge clk);
			end
			out_stall <= idle_now();
		end
	end

	initial begin
		int           roll;
		mode_t        op;
		logic [TAG_W-1:0] area;
		logic [TAG_W-1:0] room;
		logic [IDX_W-1:0] idx;
		in_valid    <= 1'b0;
		mode        <= MODE_CLEAR;
		area_id     <= '0;
		room_id     <= '0;
		enemy_index <= '0;
		arst_n      <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed beats
		send_beat(MODE_QUERY, 8'h00, 8'h00, 8'h00);   // reset mask is all ones
		send_beat(MODE_MARK,  8'h00, 8'h00, 8'h1f);   // gate bit low, no effect
		send_beat(MODE_ENTER, 8'hff, 8'hff, 8'h00);   // matches reset tags, lowest index
		send_beat(MODE_QUERY, 8'h00, 8'h00, 8'hff);   // high index bits ignored
		send_beat(MODE_ENTER, 8'h00, 8'h00, 8'h00);   // miss on a table of ties
		send_beat(MODE_MARK,  8'h00, 8'h00, 8'h9f);
		send_beat(MODE_QUERY, 8'h00, 8'h00, 8'h1f);
		send_beat(MODE_QUERY, 8'h00, 8'h00, 8'he0);
		send_beat(MODE_MARK,  8'h00, 8'h00, 8'h80);
		send_beat(MODE_QUERY, 8'h00, 8'h00, 8'h60);
		for (int i = 1; i <= 9; i++)
			send_beat(MODE_ENTER, 8'(i), 8'(8'h80 | i), 8'(~i));
		send_beat(MODE_ENTER, 8'h00, 8'h00, 8'h00);   // evicted by now
		send_beat(MODE_ENTER, 8'h09, 8'h89, 8'h00);
		send_beat(MODE_CLEAR, 8'h5a, 8'ha5, 8'hff);
		send_beat(MODE_ENTER, 8'hff, 8'hff, 8'h00);
		send_beat(MODE_QUERY, 8'h00, 8'h00, 8'h7f);
		send_beat(MODE_ENTER, 8'haa, 8'h55, 8'h00);

		for (int n = 0; n < RANDOM_BEATS; n++) begin
			roll = $urandom_range(99);
			if (roll < 2)
				op = MODE_CLEAR;
			else if (roll < 45)
				op = MODE_ENTER;
			else if (roll < 70)
				op = MODE_MARK;
			else
				op = MODE_QUERY;
			// mostly a small set of rooms, more than the table holds, so entries
			// get revisited and evicted
			if ($urandom_range(9) < 8) begin
				area = 8'($urandom_range(3));
				room = 8'($urandom_range(2));
			end else begin
				area = 8'($urandom);
				room = 8'($urandom);
			end
			idx = 8'($urandom);
			if (op == MODE_MARK && $urandom_range(3) != 0)
				idx[MARK_BIT] = 1'b1;
			send_beat(op, area, room, idx);
		end
		in_valid <= 1'b0;

		wait (outstanding == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("lru_room_memory_table_unit: match");
		else
			$display("lru_room_memory_table_unit: mismatch");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/lrt_pkg.sv
rtl/lrt_front.sv
rtl/lrt_queue.sv
rtl/lrt_back.sv
rtl/lru_room_memory_table_unit.sv
rtl/lrt_checker.sv
bench/lrt_room_table_checker.sv
bench/tb_lru_room_memory_table_unit.sv
